// File: design/i2bda_pkg.sv
`timescale 1ns / 1ps

package i2bda_pkg;

    // Defaults for the top-level parameters.
    localparam int LANES_DEFAULT      = 8;
    localparam int MAX_BLOCKS_DEFAULT = 4096;

    // Fixed field widths.
    localparam int CHUNK_BYTES = 8;
    localparam int DOT_W       = 18;
    localparam int CHUNK_W     = 5;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 13;

    localparam logic [1:0] WEIGHT_MASK = 2'h3;

    // Input item kinds.
    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_SCALE = 2'd1;
    localparam logic [1:0] KIND_CHUNK = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_BLOCK_LEN_SEL = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BLOCK_COUNT   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_BIAS_ENABLE   = 2'd2;

    // Block length selector codes.
    localparam logic [1:0] LEN_SEL_32 = 2'd0;
    localparam logic [1:0] LEN_SEL_64 = 2'd1;

    // Floating-point unit operations.
    localparam logic FOP_MUL = 1'b0;
    localparam logic FOP_ADD = 1'b1;

    // Operand selections for one step of a block fold.
    localparam logic [1:0] SEL_SCALE = 2'd0;
    localparam logic [1:0] SEL_TERM  = 2'd1;
    localparam logic [1:0] SEL_ACC   = 2'd2;
    localparam logic [1:0] SEL_CORR  = 2'd3;

    typedef struct packed {
        logic       accept;
        logic       fpu_en;
        logic [1:0] fpu_sel;
        logic       acc_load;
        logic       blk_finish;
    } i2bda_cmd_t;

    typedef struct packed {
        logic fold_start;
        logic last_block;
        logic out_valid;
    } i2bda_stat_t;

endpackage

// File: design/i2bda_fpu.sv
`timescale 1ns / 1ps

module i2bda_fpu
    import i2bda_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  logic        op,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [31:0] result_reg
);

    localparam logic [31:0] DEFAULT_NAN = 32'hFFC0_0000;
    localparam logic [31:0] QUIET_BIT   = 32'h0040_0000;

    logic [31:0] result_next;

    function automatic logic [5:0] lzc48(input logic [47:0] v);
        logic [5:0] n;
        logic       found;
        n = 6'd48;
        found = 1'b0;
        for (int i = 47; i >= 0; i--) begin
            if (!found && v[i]) begin
                n = 6'(47 - i);
                found = 1'b1;
            end
        end
        return n;
    endfunction

    function automatic logic [4:0] lzc27(input logic [26:0] v);
        logic [4:0] n;
        logic       found;
        n = 5'd27;
        found = 1'b0;
        for (int i = 26; i >= 0; i--) begin
            if (!found && v[i]) begin
                n = 5'(26 - i);
                found = 1'b1;
            end
        end
        return n;
    endfunction

    // The mantissa carries the leading one at bit 26, then 23 fraction bits,
    // then guard, round and sticky.
    function automatic logic [31:0] round_pack(input logic s, input logic signed [10:0] e,
                                               input logic [26:0] m);
        logic [26:0] mm;
        logic [10:0] sh;
        logic [26:0] lost_mask;
        logic [7:0]  ex;
        logic        inc;
        logic [30:0] body;
        if (e >= 11'sd255) begin
            return {s, 8'hFF, 23'd0};
        end
        if (e <= 11'sd0) begin
            sh = 11'(11'sd1 - e);
            if (sh >= 11'd27) begin
                mm = {26'd0, |m};
            end else begin
                lost_mask = ~(27'h7FF_FFFF << sh[4:0]);
                mm = (m >> sh[4:0]) | {26'd0, |(m & lost_mask)};
            end
            ex = 8'd0;
        end else begin
            mm = m;
            ex = e[7:0];
        end
        inc = mm[2] & (mm[1] | mm[0] | mm[3]);
        body = {ex, mm[25:3]} + {30'd0, inc};
        return {s, body};
    endfunction

    function automatic logic [31:0] fmul(input logic [31:0] x, input logic [31:0] y);
        logic               s;
        logic               x_nan, y_nan, x_inf, y_inf, x_zero, y_zero;
        logic [23:0]        mx, my;
        logic [47:0]        p, pn;
        logic [5:0]         lz;
        logic signed [10:0] e;
        s      = x[31] ^ y[31];
        x_nan  = (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
        y_nan  = (y[30:23] == 8'hFF) && (y[22:0] != 23'd0);
        x_inf  = (x[30:23] == 8'hFF) && (x[22:0] == 23'd0);
        y_inf  = (y[30:23] == 8'hFF) && (y[22:0] == 23'd0);
        x_zero = (x[30:0] == 31'd0);
        y_zero = (y[30:0] == 31'd0);
        if (x_nan) return x | QUIET_BIT;
        if (y_nan) return y | QUIET_BIT;
        if ((x_inf && y_zero) || (y_inf && x_zero)) return DEFAULT_NAN;
        if (x_inf || y_inf) return {s, 8'hFF, 23'd0};
        if (x_zero || y_zero) return {s, 31'd0};
        mx = {x[30:23] != 8'd0, x[22:0]};
        my = {y[30:23] != 8'd0, y[22:0]};
        p  = {24'd0, mx} * {24'd0, my};
        lz = lzc48(p);
        pn = p << lz;
        e  = $signed({3'd0, (x[30:23] == 8'd0) ? 8'd1 : x[30:23]})
           + $signed({3'd0, (y[30:23] == 8'd0) ? 8'd1 : y[30:23]})
           - 11'sd126 - $signed({5'd0, lz});
        return round_pack(s, e, {pn[47:22], |pn[21:0]});
    endfunction

    function automatic logic [31:0] fadd(input logic [31:0] x, input logic [31:0] y);
        logic               x_nan, y_nan, x_inf, y_inf, swap;
        logic               s1, s2, eff_sub;
        logic [7:0]         e1, e2, d;
        logic [23:0]        m1, m2;
        logic [26:0]        m1x, m2x, m2w, lost_mask, m;
        logic [27:0]        sum;
        logic [4:0]         lz;
        logic signed [10:0] e;
        x_nan = (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
        y_nan = (y[30:23] == 8'hFF) && (y[22:0] != 23'd0);
        x_inf = (x[30:23] == 8'hFF) && (x[22:0] == 23'd0);
        y_inf = (y[30:23] == 8'hFF) && (y[22:0] == 23'd0);
        if (x_nan) return x | QUIET_BIT;
        if (y_nan) return y | QUIET_BIT;
        if (x_inf && y_inf && (x[31] != y[31])) return DEFAULT_NAN;
        if (x_inf) return x;
        if (y_inf) return y;
        swap = (y[30:0] > x[30:0]);
        s1 = swap ? y[31] : x[31];
        s2 = swap ? x[31] : y[31];
        e1 = swap ? y[30:23] : x[30:23];
        e2 = swap ? x[30:23] : y[30:23];
        m1 = swap ? {y[30:23] != 8'd0, y[22:0]} : {x[30:23] != 8'd0, x[22:0]};
        m2 = swap ? {x[30:23] != 8'd0, x[22:0]} : {y[30:23] != 8'd0, y[22:0]};
        if (e1 == 8'd0) e1 = 8'd1;
        if (e2 == 8'd0) e2 = 8'd1;
        d   = e1 - e2;
        m1x = {m1, 3'd0};
        m2w = {m2, 3'd0};
        if (d >= 8'd27) begin
            m2x = {26'd0, m2 != 24'd0};
        end else begin
            lost_mask = ~(27'h7FF_FFFF << d[4:0]);
            m2x = (m2w >> d[4:0]) | {26'd0, |(m2w & lost_mask)};
        end
        eff_sub = s1 ^ s2;
        sum = eff_sub ? ({1'b0, m1x} - {1'b0, m2x}) : ({1'b0, m1x} + {1'b0, m2x});
        if (sum == 28'd0) return {eff_sub ? 1'b0 : s1, 31'd0};
        if (sum[27]) begin
            m = {sum[27:2], sum[1] | sum[0]};
            e = $signed({3'd0, e1}) + 11'sd1;
        end else begin
            lz = lzc27(sum[26:0]);
            m  = sum[26:0] << lz;
            e  = $signed({3'd0, e1}) - $signed({6'd0, lz});
        end
        return round_pack(s1, e, m);
    endfunction

    always_comb
    begin
        if (op == FOP_ADD) begin
            result_next = fadd(a, b);
        end else begin
            result_next = fmul(a, b);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            result_reg <= result_next;
        end
    end

endmodule

// File: design/i2bda_datapath.sv
`timescale 1ns / 1ps

module i2bda_datapath
    import i2bda_pkg::*;
#(
    parameter int LANES      = LANES_DEFAULT,
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  i2bda_cmd_t             cmd,
    output i2bda_stat_t            stat,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic [1:0]             kind,
    input  logic [31:0]            bias_value,
    input  logic [31:0]            a_scale,
    input  logic [31:0]            b_scale,
    input  logic [31:0]            a_blksum,
    input  logic [31:0]            b_blksum,
    input  logic [63:0]            a_bytes,
    input  logic [63:0]            b_packed,
    input  logic                   out_ready,
    output logic [31:0]            c_value,
    output logic                   out_valid
);

    // At least two bits, since the low two bits pick the weight field.
    localparam int BLK_W   = (MAX_BLOCKS > 4) ? $clog2(MAX_BLOCKS) : 2;
    localparam int CPB_32  = (32 / LANES == 0) ? 1 : 32 / LANES;
    localparam int CPB_64  = (64 / LANES == 0) ? 1 : 64 / LANES;
    localparam int CPB_128 = (128 / LANES == 0) ? 1 : 128 / LANES;

    logic [1:0]            len_sel_reg;
    logic [CFG_DATA_W-1:0] blk_count_reg;
    logic                  bias_en_reg;

    logic [31:0]           acc_reg;
    logic [DOT_W-1:0]      dot_reg;
    logic [CHUNK_W-1:0]    chunk_reg;
    logic [BLK_W-1:0]      blk_reg;
    logic                  finished_reg;
    logic [31:0]           scale_reg [4];
    logic [31:0]           c_value_reg;
    logic                  out_valid_reg;

    logic [DOT_W-1:0]      chunk_sum;
    logic [DOT_W-1:0]      dot_next;
    logic [CHUNK_W-1:0]    chunk_next;
    logic [7:0]            cpb;
    logic [17:0]           blk_eff;
    logic                  is_chunk;

    logic                  fpu_op;
    logic [31:0]           fpu_a;
    logic [31:0]           fpu_b;
    logic [31:0]           fpu_res;

    function automatic logic [31:0] int_to_float(input logic [DOT_W-1:0] v);
        logic             s;
        logic [DOT_W-1:0] mag;
        logic [DOT_W-1:0] n;
        logic [4:0]       lz;
        logic             found;
        logic [7:0]       ex;
        s = v[DOT_W-1];
        mag = s ? (~v + 1'b1) : v;
        lz = 5'd0;
        found = 1'b0;
        for (int i = DOT_W - 1; i >= 0; i--) begin
            if (!found && mag[i]) begin
                lz = 5'(DOT_W - 1 - i);
                found = 1'b1;
            end
        end
        if (!found) return 32'd0;
        n = mag << lz;
        ex = 8'(127 + DOT_W - 1) - {3'd0, lz};
        return {s, ex, n[DOT_W-2:0], (23 - (DOT_W - 1))'(0)};
    endfunction

    // Integer dot of one chunk: each lane multiplies a signed byte by a 2-bit weight.
    always_comb
    begin
        logic signed [7:0]  av;
        logic [7:0]         bb;
        logic [1:0]         w;
        logic signed [10:0] prod;
        chunk_sum = '0;
        for (int i = 0; i < LANES; i++) begin
            av = $signed(a_bytes[8 * (i % CHUNK_BYTES) +: 8]);
            bb = b_packed[8 * (i % CHUNK_BYTES) +: 8];
            w  = bb[2 * blk_reg[1:0] +: 2] & WEIGHT_MASK;
            prod = av * $signed({1'b0, w});
            chunk_sum = chunk_sum + DOT_W'(prod);
        end
    end

    always_comb
    begin
        case (len_sel_reg)
            LEN_SEL_32: cpb = 8'(CPB_32);
            LEN_SEL_64: cpb = 8'(CPB_64);
            default:    cpb = 8'(CPB_128);
        endcase
        if (blk_count_reg == '0) begin
            blk_eff = 18'd1;
        end else if (18'(blk_count_reg) > 18'(MAX_BLOCKS)) begin
            blk_eff = 18'(MAX_BLOCKS);
        end else begin
            blk_eff = 18'(blk_count_reg);
        end
    end

    assign dot_next        = dot_reg + chunk_sum;
    assign chunk_next      = chunk_reg + 1'b1;
    assign is_chunk        = (kind == KIND_CHUNK) && !finished_reg;
    assign stat.fold_start = is_chunk && (8'(chunk_next) >= cpb);
    assign stat.last_block = (18'(blk_reg) + 18'd1) >= blk_eff;
    assign stat.out_valid  = out_valid_reg;

    always_comb
    begin
        fpu_op = FOP_MUL;
        case (cmd.fpu_sel)
            SEL_SCALE:
            begin
                fpu_a = scale_reg[0];
                fpu_b = scale_reg[1];
            end
            SEL_TERM:
            begin
                fpu_a = fpu_res;
                fpu_b = int_to_float(dot_reg);
            end
            SEL_ACC:
            begin
                fpu_op = FOP_ADD;
                fpu_a  = acc_reg;
                fpu_b  = fpu_res;
            end
            default:
            begin
                fpu_a = scale_reg[2];
                fpu_b = scale_reg[3];
            end
        endcase
    end

    i2bda_fpu u_fpu (
        .clk        (clk),
        .en         (cmd.fpu_en),
        .op         (fpu_op),
        .a          (fpu_a),
        .b          (fpu_b),
        .result_reg (fpu_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            len_sel_reg   <= LEN_SEL_64;
            blk_count_reg <= CFG_DATA_W'(1);
            bias_en_reg   <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_BLOCK_LEN_SEL: len_sel_reg   <= cfg_data[1:0];
                CFG_BLOCK_COUNT:   blk_count_reg <= cfg_data;
                CFG_BIAS_ENABLE:   bias_en_reg   <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            acc_reg       <= '0;
            dot_reg       <= '0;
            chunk_reg     <= '0;
            blk_reg       <= '0;
            finished_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (out_valid_reg && out_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.accept) begin
                if (kind == KIND_START) begin
                    acc_reg      <= bias_en_reg ? bias_value : 32'd0;
                    dot_reg      <= '0;
                    chunk_reg    <= '0;
                    blk_reg      <= '0;
                    finished_reg <= 1'b0;
                end else if (is_chunk) begin
                    dot_reg   <= dot_next;
                    chunk_reg <= chunk_next;
                end
            end
            if (cmd.acc_load) begin
                acc_reg <= fpu_res;
            end
            if (cmd.blk_finish) begin
                dot_reg   <= '0;
                chunk_reg <= '0;
                if (stat.last_block) begin
                    blk_reg       <= '0;
                    finished_reg  <= 1'b1;
                    out_valid_reg <= 1'b1;
                end else begin
                    blk_reg <= blk_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && (kind == KIND_SCALE)) begin
            scale_reg[0] <= a_scale;
            scale_reg[1] <= b_scale;
            scale_reg[2] <= a_blksum;
            scale_reg[3] <= b_blksum;
        end
        if (cmd.blk_finish && stat.last_block) begin
            c_value_reg <= fpu_res;
        end
    end

    assign c_value   = c_value_reg;
    assign out_valid = out_valid_reg;

endmodule

// File: design/i2bda_ctrl.sv
`timescale 1ns / 1ps

module i2bda_ctrl
    import i2bda_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        out_ready,
    input  i2bda_stat_t stat,
    output i2bda_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_F1   = 3'd1;
    localparam logic [2:0] S_F2   = 3'd2;
    localparam logic [2:0] S_F3   = 3'd3;
    localparam logic [2:0] S_F4   = 3'd4;
    localparam logic [2:0] S_F5   = 3'd5;
    localparam logic [2:0] S_F6   = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_blocked;

    // The final fold cannot retire while an earlier result is still unread.
    assign out_blocked = stat.last_block && stat.out_valid && !out_ready;

    always_comb
    begin
        state_next     = state_reg;
        in_ready       = 1'b0;
        cmd.accept     = 1'b0;
        cmd.fpu_en     = 1'b0;
        cmd.fpu_sel    = SEL_SCALE;
        cmd.acc_load   = 1'b0;
        cmd.blk_finish = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                if (in_valid && stat.fold_start) begin
                    state_next = S_F1;
                end
            end
            S_F1:
            begin
                cmd.fpu_en  = 1'b1;
                cmd.fpu_sel = SEL_SCALE;
                state_next  = S_F2;
            end
            S_F2:
            begin
                cmd.fpu_en  = 1'b1;
                cmd.fpu_sel = SEL_TERM;
                state_next  = S_F3;
            end
            S_F3:
            begin
                cmd.fpu_en  = 1'b1;
                cmd.fpu_sel = SEL_ACC;
                state_next  = S_F4;
            end
            S_F4:
            begin
                cmd.acc_load = 1'b1;
                cmd.fpu_en   = 1'b1;
                cmd.fpu_sel  = SEL_CORR;
                state_next   = S_F5;
            end
            S_F5:
            begin
                cmd.fpu_en  = 1'b1;
                cmd.fpu_sel = SEL_ACC;
                state_next  = S_F6;
            end
            S_F6:
            begin
                cmd.acc_load = 1'b1;
                if (!out_blocked) begin
                    cmd.blk_finish = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTHESIS
    a_fold_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.accept && stat.fold_start) |=> (state_reg == S_F1))
        else $error("block fold did not start after its last chunk");

    a_retire_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_F6 && !stat.out_valid) |=> (state_reg == S_IDLE))
        else $error("fold retire stalled with an empty output register");

    a_no_fpu_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fpu_en |-> (state_reg != S_IDLE && !in_ready))
        else $error("floating-point unit issued while taking input");
`endif

endmodule

// File: design/int2_int8_block_dot_accumulator.sv
`timescale 1ns / 1ps

// Block-quantized int2 x int8 dot accumulator producing one float32 element of a
// GEMM. A start transaction loads the accumulator with the bias (or +0.0 when
// bias_enable is clear) and clears the counters, a scale transaction latches the
// four block scale values, and each data chunk transaction adds LANES signed
// activation bytes times 2-bit unsigned weights into the integer block dot. Start,
// scale and ordinary chunk transactions are accepted back to back. The chunk that
// completes a block triggers a fold that runs five steps through one shared
// single-precision multiply/add unit (scale product, scaled dot, accumulate,
// correction product, accumulate), all rounded to nearest even with no fused
// operations, and in_ready stays low until the fold retires. After block_count
// blocks the accumulator is presented on c_value; the fold of the final block
// waits if the previous result has not yet been taken. Configuration writes are
// always accepted and must only be issued while the block is idle.
module int2_int8_block_dot_accumulator
    import i2bda_pkg::*;
#(
    parameter int LANES      = LANES_DEFAULT,
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [1:0]             kind,
    input  logic [31:0]            bias_value,
    input  logic [31:0]            a_scale,
    input  logic [31:0]            b_scale,
    input  logic [31:0]            a_blksum,
    input  logic [31:0]            b_blksum,
    input  logic [63:0]            a_bytes,
    input  logic [63:0]            b_packed,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [31:0]            c_value
);

    i2bda_cmd_t  cmd;
    i2bda_stat_t stat;

    // Register writes never stall.
    assign cfg_ready = 1'b1;

    i2bda_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    i2bda_datapath #(
        .LANES      (LANES),
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .cfg_we     (cfg_valid & cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .kind       (kind),
        .bias_value (bias_value),
        .a_scale    (a_scale),
        .b_scale    (b_scale),
        .a_blksum   (a_blksum),
        .b_blksum   (b_blksum),
        .a_bytes    (a_bytes),
        .b_packed   (b_packed),
        .out_ready  (out_ready),
        .c_value    (c_value),
        .out_valid  (out_valid)
    );

endmodule
